// File: src/npc_pkg.sv
// shared types, constants and the square root step of the palette classifier
`default_nettype none
package npc_pkg;

   // palette and register file layout
   localparam int NUM_PALETTE_REGS = 4;
   localparam int PALETTE_ENTRIES  = 4;
   localparam int MAX_DIMENSION    = 4096;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int COLOR_W     = 24;
   localparam int THRESH_W    = 10;
   localparam int DIST_W      = 9;
   localparam int CLASS_W     = 2;
   localparam int COORD_W     = 12;
   localparam int MAP_W       = 17;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PALETTE_0   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PALETTE_1   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PALETTE_2   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PALETTE_3   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD   = 3'd4;

   // reset values
   localparam logic [COLOR_W-1:0] PALETTE_RESET [NUM_PALETTE_REGS] =
      '{24'hffffff, 24'h0000ff, 24'h00ff00, 24'hff0000};
   localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 10'd128;

   // map coordinate is 32 * position plus half a tile
   localparam logic [4:0] MAP_HALF_TILE = 5'b10000;

   // square root of a sum of three squared bytes (below 2^18)
   localparam int SUM_W        = 18;
   localparam int SQRT_W       = 19;
   localparam int SQRT_STEPS   = 9;
   localparam int SQRT_STAGES  = 3;
   localparam int SQRT_PER_STG = SQRT_STEPS / SQRT_STAGES;

   typedef struct packed {
      logic [31:0]        pixel_color;
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic [CLASS_W-1:0] object_class;
      logic [MAP_W-1:0]   map_x;
      logic [MAP_W-1:0]   map_y;
   } rsp_type;

   typedef struct packed {
      logic [SQRT_W-1:0] rem;
      logic [SQRT_W-1:0] root;
   } sqrt_state_type;

   // one digit of the remainder based integer square root
   function automatic sqrt_state_type sqrt_step(input sqrt_state_type cur,
                                                input logic [SQRT_W-1:0] step_bit);
      sqrt_state_type    nxt;
      logic [SQRT_W-1:0] trial;
      trial = cur.root + step_bit;
      if (cur.rem >= trial) begin
         nxt.rem  = cur.rem - trial;
         nxt.root = (cur.root >> 1) + step_bit;
      end else begin
         nxt.rem  = cur.rem;
         nxt.root = cur.root >> 1;
      end
      return nxt;
   endfunction

endpackage
`default_nettype wire

// File: src/npc_dist.sv
// pipelined color distance of one palette entry: squares, sum, three root stages
`default_nettype none
module npc_dist (
   input  wire logic                          clock,
   input  wire logic                          enable,
   input  wire logic [npc_pkg::COLOR_W-1:0]   pixel_rgb,
   input  wire logic [npc_pkg::COLOR_W-1:0]   palette_rgb,
   output logic      [npc_pkg::DIST_W-1:0]    distance
);

   logic [15:0]                  sq_ff [3];
   logic [15:0]                  sq_in [3];
   logic [npc_pkg::SUM_W-1:0]    sum_ff;
   logic [npc_pkg::SUM_W-1:0]    sum_in;
   npc_pkg::sqrt_state_type      root_ff [npc_pkg::SQRT_STAGES];
   npc_pkg::sqrt_state_type      root_in [npc_pkg::SQRT_STAGES];

   // per channel absolute difference and square
   always_comb begin
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] d;
      for (int c = 0; c < 3; c++) begin
         a = pixel_rgb[8*c +: 8];
         b = palette_rgb[8*c +: 8];
         d = (a >= b) ? (a - b) : (b - a);
         sq_in[c] = 16'(d) * 16'(d);
      end
   end

   // sum of squares
   assign sum_in = npc_pkg::SUM_W'(sq_ff[0]) + npc_pkg::SUM_W'(sq_ff[1])
                 + npc_pkg::SUM_W'(sq_ff[2]);

   // square root, three digits per stage
   for (genvar j = 0; j < npc_pkg::SQRT_STAGES; j++) begin : g_root
      always_comb begin
         npc_pkg::sqrt_state_type st;
         if (j == 0) begin
            st.rem  = npc_pkg::SQRT_W'(sum_ff);
            st.root = '0;
         end else begin
            st = root_ff[(j == 0) ? 0 : j - 1];
         end
         for (int s = 0; s < npc_pkg::SQRT_PER_STG; s++) begin
            st = npc_pkg::sqrt_step(st, npc_pkg::SQRT_W'(1) <<
                 (2 * (npc_pkg::SQRT_STEPS - 1 - (j * npc_pkg::SQRT_PER_STG + s))));
         end
         root_in[j] = st;
      end
   end

   // stage registers advance together with the pipeline
   always_ff @(posedge clock) begin
      if (enable) begin
         sq_ff   <= sq_in;
         sum_ff  <= sum_in;
         root_ff <= root_in;
      end
   end

   assign distance = root_ff[npc_pkg::SQRT_STAGES-1].root[npc_pkg::DIST_W-1:0];

endmodule
`default_nettype wire

// File: src/nearest_palette_pixel_classifier_unit.sv
// top level of the nearest palette pixel classifier
//
//   channel   direction   handshake            payload
//   req       in          req_valid/req_stall  npc_pkg::req_type
//   rsp       out         rsp_valid/rsp_stall  npc_pkg::rsp_type
//   csr       in          csr_valid/csr_ready  csr_index, csr_wdata
//
// one pixel per clock while req_stall is low; a matching pixel goes from the input
// register through squares, sum, three root stages, select and output to rsp
// unmatched, flagged or out of range pixels leave a bubble and give no transaction
// reset loads the palette and threshold defaults and clears all valid bits
// req_stall is the registered skid flag: it rises only when the output
// register and the skid buffer both hold a transaction
`default_nettype none
module nearest_palette_pixel_classifier_unit #(
   parameter int PALETTE_ENTRIES = npc_pkg::PALETTE_ENTRIES
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire npc_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output npc_pkg::rsp_type                       rsp_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [npc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [npc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int LANE_COUNT = (PALETTE_ENTRIES > npc_pkg::NUM_PALETTE_REGS) ?
                               npc_pkg::NUM_PALETTE_REGS : PALETTE_ENTRIES;
   localparam int LANE_DEPTH = 2 + npc_pkg::SQRT_STAGES;

   logic [npc_pkg::COLOR_W-1:0]    palette_ff [npc_pkg::NUM_PALETTE_REGS];
   logic [npc_pkg::COLOR_W-1:0]    palette_in [npc_pkg::NUM_PALETTE_REGS];
   logic [npc_pkg::THRESH_W-1:0]   threshold_ff;
   logic [npc_pkg::THRESH_W-1:0]   threshold_in;

   logic                           advance;
   logic [npc_pkg::COLOR_W-1:0]    pixel_ff;
   logic [npc_pkg::COLOR_W-1:0]    pixel_in;
   logic                           stage_valid_ff [LANE_DEPTH+1];
   logic                           stage_valid_in [LANE_DEPTH+1];
   logic [2*npc_pkg::COORD_W-1:0]  stage_pos_ff   [LANE_DEPTH+1];
   logic [2*npc_pkg::COORD_W-1:0]  stage_pos_in   [LANE_DEPTH+1];
   logic [npc_pkg::DIST_W-1:0]     lane_dist [LANE_COUNT];

   logic                           sel_valid_ff;
   logic                           sel_valid_in;
   npc_pkg::rsp_type               sel_data_ff;
   npc_pkg::rsp_type               sel_data_in;

   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   npc_pkg::rsp_type               rsp_data_ff;
   npc_pkg::rsp_type               rsp_data_in;
   logic                           skid_full_ff;
   logic                           skid_full_in;
   npc_pkg::rsp_type               skid_data_ff;
   npc_pkg::rsp_type               skid_data_in;

   // configuration registers, writes beyond the list are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      palette_in   = palette_ff;
      threshold_in = threshold_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            npc_pkg::CSR_PALETTE_0: palette_in[0] = csr_wdata[npc_pkg::COLOR_W-1:0];
            npc_pkg::CSR_PALETTE_1: palette_in[1] = csr_wdata[npc_pkg::COLOR_W-1:0];
            npc_pkg::CSR_PALETTE_2: palette_in[2] = csr_wdata[npc_pkg::COLOR_W-1:0];
            npc_pkg::CSR_PALETTE_3: palette_in[3] = csr_wdata[npc_pkg::COLOR_W-1:0];
            npc_pkg::CSR_THRESHOLD: threshold_in = csr_wdata[npc_pkg::THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         palette_ff   <= npc_pkg::PALETTE_RESET;
         threshold_ff <= npc_pkg::THRESHOLD_RESET;
      end else begin
         palette_ff   <= palette_in;
         threshold_ff <= threshold_in;
      end
   end

   // whole pipeline moves unless the skid buffer is occupied
   assign advance   = !skid_full_ff;
   assign req_stall = skid_full_ff;

   // input stage: flagged or out of range pixels enter as bubbles
   always_comb begin
      pixel_in          = req_data.pixel_color[npc_pkg::COLOR_W-1:0];
      stage_valid_in[0] = req_valid
                        && (req_data.pixel_color[31:npc_pkg::COLOR_W] == '0)
                        && (32'(req_data.pixel_x) < 32'(npc_pkg::MAX_DIMENSION))
                        && (32'(req_data.pixel_y) < 32'(npc_pkg::MAX_DIMENSION));
      stage_pos_in[0]   = {req_data.pixel_x, req_data.pixel_y};
      for (int k = 1; k <= LANE_DEPTH; k++) begin
         stage_valid_in[k] = stage_valid_ff[k-1];
         stage_pos_in[k]   = stage_pos_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= LANE_DEPTH; k++) begin
            stage_valid_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pixel_ff     <= pixel_in;
         stage_pos_ff <= stage_pos_in;
      end
   end

   // one distance lane per searched palette entry
   for (genvar i = 0; i < LANE_COUNT; i++) begin : g_lane
      npc_dist u_dist (
         .clock       (clock),
         .enable      (advance),
         .pixel_rgb   (pixel_ff),
         .palette_rgb (palette_ff[i]),
         .distance    (lane_dist[i])
      );
   end

   // select nearest entry strictly below threshold, lower index wins ties
   always_comb begin
      logic [npc_pkg::THRESH_W-1:0] best;
      logic [npc_pkg::CLASS_W-1:0]  cls;
      logic                         found;
      logic [npc_pkg::COORD_W-1:0]  px;
      logic [npc_pkg::COORD_W-1:0]  py;
      best  = threshold_ff;
      cls   = '0;
      found = 1'b0;
      for (int i = 0; i < LANE_COUNT; i++) begin
         if (npc_pkg::THRESH_W'(lane_dist[i]) < best) begin
            best  = npc_pkg::THRESH_W'(lane_dist[i]);
            cls   = npc_pkg::CLASS_W'(i);
            found = 1'b1;
         end
      end
      {px, py}                 = stage_pos_ff[LANE_DEPTH];
      sel_valid_in             = stage_valid_ff[LANE_DEPTH] && found;
      sel_data_in.object_class = cls;
      sel_data_in.map_x        = {px, npc_pkg::MAP_HALF_TILE};
      sel_data_in.map_y        = {py, npc_pkg::MAP_HALF_TILE};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_valid_ff <= 1'b0;
      end else if (advance) begin
         sel_valid_ff <= sel_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sel_data_ff <= sel_data_in;
      end
   end

   // output register with skid buffer
   always_comb begin
      logic take;
      take         = rsp_valid_ff && !rsp_stall;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      skid_full_in = skid_full_ff;
      skid_data_in = skid_data_ff;
      if (skid_full_ff) begin
         if (take) begin
            rsp_data_in  = skid_data_ff;
            skid_full_in = 1'b0;
         end
      end else if (sel_valid_ff) begin
         if (!rsp_valid_ff || take) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = sel_data_ff;
         end else begin
            skid_full_in = 1'b1;
            skid_data_in = sel_data_ff;
         end
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         skid_full_ff <= skid_full_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // skid buffer only fills behind a waiting output transaction
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> rsp_valid_ff)
      else $error("skid buffer full with empty output register");

   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_full_ff) |-> $past(rsp_valid_ff && rsp_stall && sel_valid_ff))
      else $error("skid buffer filled without a stalled output");

   a_class_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (32'(rsp_data_ff.object_class) < 32'(LANE_COUNT)))
      else $error("class index beyond searched palette entries");

   a_map_half_tile: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.map_x[4:0] == npc_pkg::MAP_HALF_TILE)
                    && (rsp_data_ff.map_y[4:0] == npc_pkg::MAP_HALF_TILE))
      else $error("map coordinate off the tile center");

endmodule
`default_nettype wire
